### sv/olid_pkg.sv
// Shared constants, codes and types for the ordered list insert and dump unit.
package olid_pkg;

    localparam int DEPTH   = 32;
    localparam int DATA_W  = 32;
    localparam int POS_W   = 6;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int S_TDATA_W = ((DATA_W + POS_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((DATA_W + 7) / 8) * 8;
    localparam int S_TUSER_W = CMD_W;
    localparam int M_TUSER_W = STAT_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_INS_FRONT = 2'd0,
        CMD_INS_END   = 2'd1,
        CMD_INS_POS   = 2'd2,
        CMD_DUMP      = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_BADPOS = 2'd1,
        STAT_FULL   = 2'd2,
        STAT_EMPTY  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_ROTATE = 2'd2
    } t_cell_op;

    // Broadcast control from the sequencer to every cell of the chain
    typedef struct packed {
        t_cell_op          op;
        logic [IDX_W-1:0]  ins_idx;   // slot that takes the new value
        logic [IDX_W-1:0]  tail_idx;  // slot of the last stored entry
        logic [DATA_W-1:0] new_val;
        logic [DATA_W-1:0] head_val;  // front entry, wraps to the tail on rotate
    } t_cell_ctrl;

endpackage

### sv/ordered_list_insert_and_dump_unit.sv
// Ordered list unit: chain of storage cells with an insert/dump sequencer.
// Insert: its status beat is shown the next cycle after accept.
// Throughput: one insert per cycle while the result side keeps up.
// Dump: count beats (one when empty), one per cycle unless stalled; the first beat
//   loads in ST_DUMP (next cycle when empty); input stalls until the last beat loads.
// Reset (i_rst_n low, synchronous) empties the list and clears the output valid.
module ordered_list_insert_and_dump_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [31:0] value, [37:32] position, [39:38] zero
    input  logic [olid_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // [1:0] cmd
    input  logic [olid_pkg::S_TUSER_W-1:0] s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [31:0] item
    output logic [olid_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // [1:0] status
    output logic [olid_pkg::M_TUSER_W-1:0] m_axis_tuser,
    output logic                           m_axis_tlast
);
    import olid_pkg::*;

    localparam int CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_remain;
    logic               r_m_tvalid;
    logic [DATA_W-1:0]  r_m_item;
    t_status            r_m_status;
    logic               r_m_tlast;

    logic               w_slot_free;
    logic               w_in_acc;
    logic               w_out_load;
    t_cmd               w_cmd;
    logic [DATA_W-1:0]  w_value;
    logic [POS_W-1:0]   w_pos;
    logic               w_full;
    logic               w_do_ins;
    t_status            w_ins_status;
    logic [IDX_W-1:0]   w_ins_idx;
    logic [CMP_W-1:0]   w_pos_ext;
    logic [CMP_W-1:0]   w_cnt_p1;
    t_cell_ctrl         w_ctrl;
    logic [DATA_W-1:0]  w_cell_val [DEPTH];

    assign w_cmd   = t_cmd'(s_axis_tuser[CMD_W-1:0]);
    assign w_value = s_axis_tdata[DATA_W-1:0];
    assign w_pos   = s_axis_tdata[DATA_W+POS_W-1:DATA_W];

    assign w_slot_free   = !r_m_tvalid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE) && w_slot_free;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    // Output register takes a new beat this cycle
    assign w_out_load = ((r_state == ST_IDLE) && w_in_acc
                         && ((w_cmd != CMD_DUMP) || (r_count == '0)))
                        || ((r_state == ST_DUMP) && w_slot_free);

    assign w_full    = (r_count == CNT_W'(DEPTH));
    assign w_pos_ext = CMP_W'(w_pos);
    assign w_cnt_p1  = CMP_W'(r_count) + CMP_W'(1);

    always_comb begin
        w_do_ins     = 1'b0;
        w_ins_status = STAT_OK;
        w_ins_idx    = '0;
        if (w_full) begin
            w_ins_status = STAT_FULL;
        end else begin
            case (w_cmd)
                CMD_INS_FRONT: begin
                    w_do_ins  = 1'b1;
                    w_ins_idx = '0;
                end
                CMD_INS_END: begin
                    w_do_ins  = 1'b1;
                    w_ins_idx = IDX_W'(r_count);
                end
                CMD_INS_POS: begin
                    if (w_pos == '0 || w_pos_ext > w_cnt_p1) begin
                        w_ins_status = STAT_BADPOS;
                    end else begin
                        w_do_ins  = 1'b1;
                        w_ins_idx = IDX_W'(w_pos - POS_W'(1));
                    end
                end
                default: w_do_ins = 1'b0;
            endcase
        end
    end

    always_comb begin
        w_ctrl.op       = CELL_HOLD;
        w_ctrl.ins_idx  = w_ins_idx;
        w_ctrl.tail_idx = IDX_W'(r_count - CNT_W'(1));
        w_ctrl.new_val  = w_value;
        w_ctrl.head_val = w_cell_val[0];
        if (w_in_acc && w_cmd != CMD_DUMP && w_do_ins) begin
            w_ctrl.op = CELL_INSERT;
        end else if (r_state == ST_DUMP && w_slot_free) begin
            w_ctrl.op = CELL_ROTATE;
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_W-1:0] w_left;
        logic [DATA_W-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_cell_val[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_right = w_cell_val[0];
        end else begin : g_mid_r
            assign w_right = w_cell_val[g+1];
        end
        olid_cell u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (w_ctrl),
            .i_index     (IDX_W'(g)),
            .i_left_val  (w_left),
            .i_right_val (w_right),
            .o_val       (w_cell_val[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_count    <= '0;
            r_remain   <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_m_tvalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_tvalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        if (w_cmd == CMD_DUMP) begin
                            if (r_count == '0) begin
                                r_m_item   <= '0;
                                r_m_status <= STAT_EMPTY;
                                r_m_tlast  <= 1'b1;
                            end else begin
                                r_state  <= ST_DUMP;
                                r_remain <= r_count;
                            end
                        end else begin
                            r_m_item   <= '0;
                            r_m_status <= w_ins_status;
                            r_m_tlast  <= 1'b1;
                            if (w_do_ins) begin
                                r_count <= r_count + CNT_W'(1);
                            end
                        end
                    end
                end
                ST_DUMP: begin
                    if (w_slot_free) begin
                        r_m_item   <= w_cell_val[0];
                        r_m_status <= STAT_OK;
                        r_m_tlast  <= (r_remain == CNT_W'(1));
                        r_remain   <= r_remain - CNT_W'(1);
                        if (r_remain == CNT_W'(1)) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = M_TDATA_W'(r_m_item);
    assign m_axis_tuser  = M_TUSER_W'(r_m_status);
    assign m_axis_tlast  = r_m_tlast;

endmodule

### sv/olid_cell.sv
// One storage cell of the list chain: holds, takes a new value, or shifts.
module olid_cell (
    input  logic                        i_clk,
    input  olid_pkg::t_cell_ctrl        i_ctrl,
    input  logic [olid_pkg::IDX_W-1:0]  i_index,
    input  logic [olid_pkg::DATA_W-1:0] i_left_val,
    input  logic [olid_pkg::DATA_W-1:0] i_right_val,
    output logic [olid_pkg::DATA_W-1:0] o_val
);
    import olid_pkg::*;

    logic [DATA_W-1:0] r_val;
    logic [DATA_W-1:0] n_val;

    always_comb begin
        n_val = r_val;
        case (i_ctrl.op)
            CELL_INSERT: begin
                if (i_index == i_ctrl.ins_idx) begin
                    n_val = i_ctrl.new_val;
                end else if (i_index > i_ctrl.ins_idx) begin
                    n_val = i_left_val;
                end
            end
            CELL_ROTATE: begin
                // Tail takes the head so the list is whole again after count shifts
                if (i_index == i_ctrl.tail_idx) begin
                    n_val = i_ctrl.head_val;
                end else begin
                    n_val = i_right_val;
                end
            end
            default: n_val = r_val;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;

endmodule

### sv/olid_checker.sv
// Port-level checks for the ordered list unit, bound to the top level.
module olid_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [olid_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input logic [olid_pkg::S_TUSER_W-1:0] s_axis_tuser,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [olid_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic [olid_pkg::M_TUSER_W-1:0] m_axis_tuser,
    input logic                           m_axis_tlast
);
    import olid_pkg::*;

    logic w_ins_acc;
    assign w_ins_acc = s_axis_tvalid && s_axis_tready
                       && (s_axis_tuser[CMD_W-1:0] != CMD_DUMP);

    // Stalled result beat must hold
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("result beat changed while stalled");

    // Input is only taken when the output register can make room
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready && m_axis_tvalid |-> m_axis_tready)
        else $error("input ready while output slot is blocked");

    // Every insert gives a single status beat on the next cycle
    a_ins_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ins_acc |=> m_axis_tvalid && m_axis_tlast && (m_axis_tdata == '0)
        && (m_axis_tuser != STAT_EMPTY))
        else $error("insert did not produce one status beat");

    // Non-ok status beats are always single, zero-item beats
    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != STAT_OK) |-> m_axis_tlast && (m_axis_tdata == '0))
        else $error("error status beat with data or without last");

endmodule

bind ordered_list_insert_and_dump_unit olid_checker u_olid_checker (.*);
